// ===== hdl/ndat_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ndat_pkg;

    localparam int BLOCK_ENTRIES = 4096;
    localparam int PATCH_SLOTS   = 32;
    localparam int SLOT_W        = $clog2(PATCH_SLOTS);
    localparam int BLK_W         = 12;

    localparam logic [14:0] MAX_REQUEST  = 15'd16384;
    localparam logic [13:0] PAGE_BYTES   = 14'd8832;
    localparam logic [10:0] SECTOR_BYTES = 11'd1024;
    localparam logic [10:0] SECTOR_PITCH = 11'd1094;  // sector plus 70 bytes of ECC

    // request types
    localparam logic [1:0] REQ_WRITE     = 2'd0;
    localparam logic [1:0] REQ_INSTALL   = 2'd1;
    localparam logic [1:0] REQ_TRANSLATE = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_ACK   = 3'd0;
    localparam logic [2:0] KIND_CHIP  = 3'd1;
    localparam logic [2:0] KIND_PATCH = 3'd2;
    localparam logic [2:0] KIND_ZERO  = 3'd3;
    localparam logic [2:0] KIND_END   = 3'd4;

    // ack status codes
    localparam logic [1:0] ACK_WRITTEN = 2'd0;
    localparam logic [1:0] ACK_KEPT    = 2'd1;
    localparam logic [1:0] ACK_FULL    = 2'd2;
    localparam logic [1:0] ACK_IGNORED = 2'd3;

    // config register index
    localparam logic REG_TABLE_SIZE = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_SCAN,
        ST_CHUNK,
        ST_TBL_CHK,
        ST_PSCAN,
        ST_FORM,
        ST_EMIT
    } ndat_state_t;

    typedef struct packed {
        logic       load_in;
        logic       tbl_wr;
        logic       tbl_rd;
        logic       scan_clr;
        logic       scan_inc;
        logic       slot_wr;
        logic       out_ack;
        logic [1:0] ack_status;
        logic       out_end;
        logic       out_zero;
        logic       mul_patch;
        logic       mul_chip;
        logic       form_read;
        logic       advance;
    } ndat_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       sector_zero;
        logic       size_zero;
        logic       past_end;
        logic       mapped;
        logic       slot_match;
        logic       conf_gt;
        logic       slot_hit;
        logic       idx_last;
        logic       out_last;
    } ndat_sts_t;

endpackage
`default_nettype wire

// ===== hdl/ndat_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ndat_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire ndat_pkg::ndat_sts_t sts,
    output ndat_pkg::ndat_cmd_t    cmd
);

    ndat_pkg::ndat_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ndat_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ndat_pkg::ST_IDLE: begin
                if (s_valid) state_next = ndat_pkg::ST_DISPATCH;
            end
            ndat_pkg::ST_DISPATCH: begin
                case (sts.req_type)
                    ndat_pkg::REQ_WRITE: state_next = ndat_pkg::ST_EMIT;
                    ndat_pkg::REQ_INSTALL: begin
                        state_next = sts.sector_zero ? ndat_pkg::ST_EMIT
                                                     : ndat_pkg::ST_INS_SCAN;
                    end
                    ndat_pkg::REQ_TRANSLATE: begin
                        state_next = sts.size_zero ? ndat_pkg::ST_IDLE : ndat_pkg::ST_CHUNK;
                    end
                    default: state_next = ndat_pkg::ST_EMIT;
                endcase
            end
            ndat_pkg::ST_INS_SCAN: begin
                if (sts.slot_match || sts.idx_last) state_next = ndat_pkg::ST_EMIT;
            end
            ndat_pkg::ST_CHUNK: begin
                state_next = sts.past_end ? ndat_pkg::ST_EMIT : ndat_pkg::ST_TBL_CHK;
            end
            ndat_pkg::ST_TBL_CHK: begin
                state_next = sts.mapped ? ndat_pkg::ST_PSCAN : ndat_pkg::ST_EMIT;
            end
            ndat_pkg::ST_PSCAN: begin
                if (sts.slot_hit || sts.idx_last) state_next = ndat_pkg::ST_FORM;
            end
            ndat_pkg::ST_FORM: state_next = ndat_pkg::ST_EMIT;
            ndat_pkg::ST_EMIT: begin
                if (m_ready) begin
                    state_next = sts.out_last ? ndat_pkg::ST_IDLE : ndat_pkg::ST_CHUNK;
                end
            end
            default: state_next = ndat_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ndat_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                cmd.load_in = s_valid;
            end
            ndat_pkg::ST_DISPATCH: begin
                case (sts.req_type)
                    ndat_pkg::REQ_WRITE: begin
                        cmd.tbl_wr = 1'b1;
                        cmd.out_ack = 1'b1;
                        cmd.ack_status = ndat_pkg::ACK_WRITTEN;
                    end
                    ndat_pkg::REQ_INSTALL: begin
                        cmd.scan_clr = 1'b1;
                        cmd.out_ack = sts.sector_zero;
                        cmd.ack_status = ndat_pkg::ACK_IGNORED;
                    end
                    ndat_pkg::REQ_TRANSLATE: begin
                    end
                    default: begin
                        cmd.out_ack = 1'b1;
                        cmd.ack_status = ndat_pkg::ACK_IGNORED;
                    end
                endcase
            end
            ndat_pkg::ST_INS_SCAN: begin
                if (sts.slot_match) begin
                    cmd.slot_wr = sts.conf_gt;
                    cmd.out_ack = 1'b1;
                    cmd.ack_status = sts.conf_gt ? ndat_pkg::ACK_WRITTEN : ndat_pkg::ACK_KEPT;
                end else if (sts.idx_last) begin
                    cmd.out_ack = 1'b1;
                    cmd.ack_status = ndat_pkg::ACK_FULL;
                end else begin
                    cmd.scan_inc = 1'b1;
                end
            end
            ndat_pkg::ST_CHUNK: begin
                cmd.out_end = sts.past_end;
                cmd.tbl_rd = !sts.past_end;
                cmd.scan_clr = 1'b1;
            end
            ndat_pkg::ST_TBL_CHK: begin
                cmd.out_zero = !sts.mapped;
            end
            ndat_pkg::ST_PSCAN: begin
                cmd.mul_patch = sts.slot_hit;
                cmd.mul_chip = !sts.slot_hit && sts.idx_last;
                cmd.scan_inc = !sts.slot_hit && !sts.idx_last;
            end
            ndat_pkg::ST_FORM: cmd.form_read = 1'b1;
            ndat_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                cmd.advance = m_ready && !sts.out_last;
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_scan_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ndat_pkg::ST_PSCAN && !sts.slot_hit && !sts.idx_last)
        |=> state_reg == ndat_pkg::ST_PSCAN)
        else $error("patch scan left early");
    a_form_to_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ndat_pkg::ST_FORM |=> m_valid)
        else $error("formed read not presented");
    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == ndat_pkg::ST_DISPATCH)
        else $error("accepted transaction not dispatched");
    a_one_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.out_ack, cmd.out_end, cmd.out_zero, cmd.form_read}))
        else $error("multiple result loads");
`endif

endmodule
`default_nettype wire

// ===== hdl/ndat_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ndat_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ndat_pkg::ndat_cmd_t cmd,
    output ndat_pkg::ndat_sts_t      sts,
    input  wire logic [12:0]         table_size,
    input  wire logic [1:0]          s_req_type,
    input  wire logic [33:0]         s_byte_offset,
    input  wire logic [14:0]         s_request_length,
    input  wire logic [11:0]         s_block_index,
    input  wire logic [15:0]         s_phys_block,
    input  wire logic                s_block_mapped,
    input  wire logic [31:0]         s_patch_sector,
    input  wire logic [15:0]         s_patch_page,
    input  wire logic signed [15:0]  s_patch_confidence,
    input  wire logic [3:0]          s_patch_source,
    output logic [2:0]               m_kind,
    output logic [1:0]               m_status,
    output logic                     m_chip_select,
    output logic [3:0]               m_source_id,
    output logic [37:0]              m_phys_address,
    output logic [10:0]              m_chunk_length,
    output logic                     m_last
);

    logic [1:0]         type_reg;
    logic [34:0]        off_reg;   // one spare bit: a run may step past the 16 GiB image
    logic [14:0]        size_reg;
    logic [11:0]        blk_idx_reg;
    logic [15:0]        phys_reg;
    logic               mapped_reg;
    logic [31:0]        psec_reg;
    logic [15:0]        ppage_reg;
    logic signed [15:0] pconf_reg;
    logic [3:0]         psrc_reg;

    logic [16:0] tbl_mem [ndat_pkg::BLOCK_ENTRIES];
    logic [16:0] entry_reg;

    logic [31:0]        slot_sector_reg [ndat_pkg::PATCH_SLOTS];
    logic [15:0]        slot_page_reg   [ndat_pkg::PATCH_SLOTS];
    logic signed [15:0] slot_conf_reg   [ndat_pkg::PATCH_SLOTS];
    logic [3:0]         slot_source_reg [ndat_pkg::PATCH_SLOTS];
    logic [ndat_pkg::SLOT_W-1:0] idx_reg;

    logic [37:0] prod_reg;
    logic [2:0]  kind_sel_reg;
    logic        cs_sel_reg;
    logic [3:0]  src_sel_reg;

    logic [31:0] cur_sec;
    logic [10:0] room;
    logic [10:0] len;
    logic        chunk_last;
    logic [13:0] tail;
    logic [23:0] mul_a;

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            type_reg    <= s_req_type;
            off_reg     <= {1'b0, s_byte_offset};
            size_reg    <= (s_request_length > ndat_pkg::MAX_REQUEST) ? ndat_pkg::MAX_REQUEST
                                                                       : s_request_length;
            blk_idx_reg <= s_block_index;
            phys_reg    <= s_phys_block;
            mapped_reg  <= s_block_mapped;
            psec_reg    <= s_patch_sector;
            ppage_reg   <= s_patch_page;
            pconf_reg   <= s_patch_confidence;
            psrc_reg    <= s_patch_source;
        end else if (cmd.advance) begin
            off_reg  <= off_reg + {24'd0, len};
            size_reg <= size_reg - {4'd0, len};
        end
    end

    // block table memory
    always_ff @(posedge aclk) begin
        if (cmd.tbl_wr) tbl_mem[blk_idx_reg] <= {mapped_reg, phys_reg};
        if (cmd.tbl_rd) entry_reg <= tbl_mem[off_reg[33:22]];
    end

    // patch slots, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ndat_pkg::PATCH_SLOTS; i++) begin
                slot_sector_reg[i] <= '0;
                slot_page_reg[i]   <= '0;
                slot_conf_reg[i]   <= '0;
                slot_source_reg[i] <= '0;
            end
        end else if (cmd.slot_wr) begin
            slot_sector_reg[idx_reg] <= psec_reg;
            slot_page_reg[idx_reg]   <= ppage_reg;
            slot_conf_reg[idx_reg]   <= pconf_reg;
            slot_source_reg[idx_reg] <= psrc_reg;
        end
    end

    // scan index
    always_ff @(posedge aclk) begin
        if (cmd.scan_clr) begin
            idx_reg <= '0;
        end else if (cmd.scan_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // chunk geometry
    assign cur_sec    = slot_sector_reg[idx_reg];
    assign room       = ndat_pkg::SECTOR_BYTES - {1'b0, off_reg[9:0]};
    assign len        = ({4'd0, room} > size_reg) ? size_reg[10:0] : room;
    assign chunk_last = ({4'd0, len} == size_reg);
    assign tail       = ({11'd0, off_reg[12:10]} * {3'd0, ndat_pkg::SECTOR_PITCH})
                        + {4'd0, off_reg[9:0]};
    // chip page pair index: physical block, then interleaved page over two
    assign mul_a      = cmd.mul_patch ? {8'd0, slot_page_reg[idx_reg]}
                                      : {entry_reg[15:0], off_reg[13], off_reg[21:15]};

    // status
    always_comb begin
        sts.req_type    = type_reg;
        sts.sector_zero = (psec_reg == '0);
        sts.size_zero   = (size_reg == '0);
        sts.past_end    = (off_reg[34:22] >= table_size);
        sts.mapped      = entry_reg[16];
        sts.slot_match  = (cur_sec == '0) || (cur_sec == psec_reg);
        sts.conf_gt     = (pconf_reg > slot_conf_reg[idx_reg]);
        sts.slot_hit    = (cur_sec != '0) && (cur_sec[31:4] == {7'd0, off_reg[33:13]});
        sts.idx_last    = (idx_reg == ndat_pkg::SLOT_W'(ndat_pkg::PATCH_SLOTS - 1));
        sts.out_last    = m_last;
    end

    // page address multiply
    always_ff @(posedge aclk) begin
        if (cmd.mul_patch || cmd.mul_chip) begin
            prod_reg     <= {14'd0, mul_a} * {24'd0, ndat_pkg::PAGE_BYTES};
            kind_sel_reg <= cmd.mul_patch ? ndat_pkg::KIND_PATCH : ndat_pkg::KIND_CHIP;
            cs_sel_reg   <= cmd.mul_patch ? 1'b0 : off_reg[14];
            src_sel_reg  <= cmd.mul_patch ? slot_source_reg[idx_reg] : 4'd0;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_ack || cmd.out_end || cmd.out_zero) begin
            m_kind         <= cmd.out_ack ? ndat_pkg::KIND_ACK
                            : cmd.out_end ? ndat_pkg::KIND_END : ndat_pkg::KIND_ZERO;
            m_status       <= cmd.out_ack ? cmd.ack_status : 2'd0;
            m_chip_select  <= 1'b0;
            m_source_id    <= 4'd0;
            m_phys_address <= '0;
            m_chunk_length <= cmd.out_zero ? len : 11'd0;
            m_last         <= cmd.out_zero ? chunk_last : 1'b1;
        end else if (cmd.form_read) begin
            m_kind         <= kind_sel_reg;
            m_status       <= 2'd0;
            m_chip_select  <= cs_sel_reg;
            m_source_id    <= src_sel_reg;
            m_phys_address <= prod_reg + {24'd0, tail};
            m_chunk_length <= len;
            m_last         <= chunk_last;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/nand_dump_address_translator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Flash image address translator.
// Input channel (s_*): one transaction per request. Write stores a block
// table entry, install merges a patch into the 32-slot patch table, translate
// splits a logical read at 1024-byte sectors into chunk descriptors.
// Result channel (m_*): one ack per write or install, 0 to 17 descriptors per
// translate; m_last marks the final result of each request.
// Config: APB write of table_size at address 0; pready is always high.
// Sequence: one request is handled at a time. Write: dispatch writes the
// block table entry and loads the ack. Install: slots are scanned one per
// cycle up to a matching or free slot or the last one. Translate, per chunk:
// an end marker or a block table read, then a zero fill for an unmapped
// block, else a patch scan of one slot per cycle and a multiply stage before
// the read is formed. Each further chunk starts after the previous result is
// taken. A zero-length read gives no result and the input is ready again.
// The patch scan is sequential and the block table has a single read port.
// Reset clears the patch table and table_size; block table contents are
// undefined until written. A stalled receiver holds the result register and
// the block stays busy until m_ready takes it.
module nand_dump_address_translator_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_req_type,
    input  wire logic [33:0]        s_byte_offset,
    input  wire logic [14:0]        s_request_length,
    input  wire logic [11:0]        s_block_index,
    input  wire logic [15:0]        s_phys_block,
    input  wire logic               s_block_mapped,
    input  wire logic [31:0]        s_patch_sector,
    input  wire logic [15:0]        s_patch_page,
    input  wire logic signed [15:0] s_patch_confidence,
    input  wire logic [3:0]         s_patch_source,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_kind,
    output logic [1:0]              m_status,
    output logic                    m_chip_select,
    output logic [3:0]              m_source_id,
    output logic [37:0]             m_phys_address,
    output logic [10:0]             m_chunk_length,
    output logic                    m_last
);

    logic [12:0] table_size_reg;
    ndat_pkg::ndat_cmd_t cmd;
    ndat_pkg::ndat_sts_t sts;

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == ndat_pkg::REG_TABLE_SIZE) begin
            table_size_reg <= pwdata[12:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ndat_pkg::REG_TABLE_SIZE) ? {19'd0, table_size_reg} : 32'd0;

    ndat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ndat_datapath u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .table_size         (table_size_reg),
        .s_req_type         (s_req_type),
        .s_byte_offset      (s_byte_offset),
        .s_request_length   (s_request_length),
        .s_block_index      (s_block_index),
        .s_phys_block       (s_phys_block),
        .s_block_mapped     (s_block_mapped),
        .s_patch_sector     (s_patch_sector),
        .s_patch_page       (s_patch_page),
        .s_patch_confidence (s_patch_confidence),
        .s_patch_source     (s_patch_source),
        .m_kind             (m_kind),
        .m_status           (m_status),
        .m_chip_select      (m_chip_select),
        .m_source_id        (m_source_id),
        .m_phys_address     (m_phys_address),
        .m_chunk_length     (m_chunk_length),
        .m_last             (m_last)
    );

endmodule
`default_nettype wire

// ===== tb/nand_dump_address_translator_top_tb.sv =====
`timescale 1ns / 1ps
module nand_dump_address_translator_top_tb;

    localparam longint CYCLE_LIMIT = 5_000_000;
    localparam longint BLOCK_SPAN  = 64'd4194304;   // 4 MiB logical block

    typedef struct packed {
        logic [1:0]         req_type;
        logic [33:0]        byte_offset;
        logic [14:0]        request_length;
        logic [11:0]        block_index;
        logic [15:0]        phys_block;
        logic               block_mapped;
        logic [31:0]        patch_sector;
        logic [15:0]        patch_page;
        logic signed [15:0] patch_confidence;
        logic [3:0]         patch_source;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  status;
        logic        chip_select;
        logic [3:0]  source_id;
        logic [37:0] phys_address;
        logic [10:0] chunk_length;
        logic        last;
    } desc_t;

    // directed row: a config write or a transaction, optionally with a typed answer
    typedef struct {
        bit    cfg;
        int    cfg_value;
        req_t  req;
        bit    typed;
        desc_t answer;
    } row_t;

    logic aclk, aresetn;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic s_valid, s_ready;
    req_t s_req;
    logic m_valid, m_ready;
    desc_t m_desc;

    nand_dump_address_translator_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req.req_type), .s_byte_offset(s_req.byte_offset),
        .s_request_length(s_req.request_length), .s_block_index(s_req.block_index),
        .s_phys_block(s_req.phys_block), .s_block_mapped(s_req.block_mapped),
        .s_patch_sector(s_req.patch_sector), .s_patch_page(s_req.patch_page),
        .s_patch_confidence(s_req.patch_confidence), .s_patch_source(s_req.patch_source),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_kind(m_desc.kind), .m_status(m_desc.status),
        .m_chip_select(m_desc.chip_select), .m_source_id(m_desc.source_id),
        .m_phys_address(m_desc.phys_address), .m_chunk_length(m_desc.chunk_length),
        .m_last(m_desc.last)
    );

    // shadow state of the translator
    logic [16:0]        blk_map [ndat_pkg::BLOCK_ENTRIES];
    bit                 blk_written [ndat_pkg::BLOCK_ENTRIES];
    logic [31:0]        sh_sector [ndat_pkg::PATCH_SLOTS];
    logic [15:0]        sh_page [ndat_pkg::PATCH_SLOTS];
    logic signed [15:0] sh_conf [ndat_pkg::PATCH_SLOTS];
    logic [3:0]         sh_src [ndat_pkg::PATCH_SLOTS];
    int unsigned        sh_table_size;

    desc_t  pending_desc[$];
    int     fail_count;
    longint cycle_count;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic desc_t make_desc(logic [2:0] kind, logic [1:0] status, logic cs,
                                        logic [3:0] src, logic [37:0] addr,
                                        logic [10:0] len);
        desc_t d;
        d.kind = kind; d.status = status; d.chip_select = cs; d.source_id = src;
        d.phys_address = addr; d.chunk_length = len; d.last = 1'b0;
        return d;
    endfunction

    function automatic logic [1:0] merge_patch(req_t r);
        int j;
        if (r.patch_sector == 0) return ndat_pkg::ACK_IGNORED;
        for (j = 0; j < ndat_pkg::PATCH_SLOTS; j++)
            if (sh_sector[j] == 0 || sh_sector[j] == r.patch_sector) break;
        if (j == ndat_pkg::PATCH_SLOTS) return ndat_pkg::ACK_FULL;
        if (r.patch_confidence > sh_conf[j]) begin
            sh_sector[j] = r.patch_sector;
            sh_page[j]   = r.patch_page;
            sh_conf[j]   = r.patch_confidence;
            sh_src[j]    = r.patch_source;
            return ndat_pkg::ACK_WRITTEN;
        end
        return ndat_pkg::ACK_KEPT;
    endfunction

    // expected descriptors for one transaction, appended in order
    function automatic void predict_descs(req_t r, ref desc_t q[$]);
        longint unsigned ofs, end_ofs, blk, tail, lp, addr;
        int unsigned remain, secofs, clen, sec, lpage, pg;
        int hit, i, first;
        first = q.size();
        case (r.req_type)
            ndat_pkg::REQ_WRITE: begin
                blk_map[r.block_index] = {r.block_mapped, r.phys_block};
                blk_written[r.block_index] = 1'b1;
                q.push_back(make_desc(ndat_pkg::KIND_ACK, ndat_pkg::ACK_WRITTEN, 0, 0, 0, 0));
            end
            ndat_pkg::REQ_INSTALL:
                q.push_back(make_desc(ndat_pkg::KIND_ACK, merge_patch(r), 0, 0, 0, 0));
            ndat_pkg::REQ_TRANSLATE: begin
                ofs = r.byte_offset;
                remain = (r.request_length > ndat_pkg::MAX_REQUEST) ? ndat_pkg::MAX_REQUEST
                                                                    : r.request_length;
                end_ofs = longint'(sh_table_size) * BLOCK_SPAN;
                while (remain != 0) begin
                    blk = ofs / BLOCK_SPAN;
                    secofs = ofs % 1024;
                    clen = 1024 - secofs;
                    if (clen > remain) clen = remain;
                    if (ofs >= end_ofs || blk >= ndat_pkg::BLOCK_ENTRIES) begin
                        q.push_back(make_desc(ndat_pkg::KIND_END, 0, 0, 0, 0, 0));
                        break;
                    end
                    sec = (ofs % 8192) / 1024;
                    tail = sec * 1094 + secofs;
                    if (!blk_map[blk][16]) begin
                        q.push_back(make_desc(ndat_pkg::KIND_ZERO, 0, 0, 0, 0, clen));
                    end else begin
                        lp = ofs / 8192;
                        hit = -1;
                        for (i = 0; i < ndat_pkg::PATCH_SLOTS; i++)
                            if (sh_sector[i] != 0 && (sh_sector[i] / 16) == lp) begin
                                hit = i;
                                break;
                            end
                        if (hit >= 0) begin
                            addr = longint'(sh_page[hit]) * 8832 + tail;
                            q.push_back(make_desc(ndat_pkg::KIND_PATCH, 0, 0, sh_src[hit],
                                                  addr, clen));
                        end else begin
                            lpage = (ofs % BLOCK_SPAN) / 8192;
                            pg = (lpage >> 1) + ((lpage & 1) << 8);
                            addr = (longint'(blk_map[blk][15:0]) * 256 + (pg >> 1)) * 8832
                                   + tail;
                            q.push_back(make_desc(ndat_pkg::KIND_CHIP, 0, pg[0], 0, addr,
                                                  clen));
                        end
                    end
                    remain -= clen;
                    ofs += clen;
                end
            end
            default:
                q.push_back(make_desc(ndat_pkg::KIND_ACK, ndat_pkg::ACK_IGNORED, 0, 0, 0, 0));
        endcase
        if (q.size() > first) q[q.size() - 1].last = 1'b1;
    endfunction

    // input side: optional gap, then hold valid until the transaction is taken
    task automatic send_req(req_t r, bit typed, desc_t answer);
        int gap;
        desc_t fresh[$];
        gap = ($urandom_range(0, 3) == 0) ? 0 :
              (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_req = r;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_descs(r, fresh);
        if (typed) begin
            answer.last = 1'b1;
            fresh = '{answer};
        end
        foreach (fresh[k]) pending_desc.push_back(fresh[k]);
        @(negedge aclk);
    endtask

    // reads never touch an entry that was not written: write it first
    task automatic cover_blocks(req_t r);
        longint unsigned span, b;
        req_t w;
        desc_t none;
        span = (r.request_length > ndat_pkg::MAX_REQUEST) ? ndat_pkg::MAX_REQUEST
                                                          : r.request_length;
        if (span == 0) return;
        none = '0;
        for (b = r.byte_offset / BLOCK_SPAN; b <= (r.byte_offset + span - 1) / BLOCK_SPAN; b++)
            if (b < sh_table_size && b < ndat_pkg::BLOCK_ENTRIES && !blk_written[b]) begin
                w = '0;
                w.req_type = ndat_pkg::REQ_WRITE;
                w.block_index = b;
                w.phys_block = $urandom();
                w.block_mapped = ($urandom_range(0, 4) != 0);
                send_req(w, 1'b0, none);
            end
    endtask

    // table_size is written only once the block has drained
    task automatic set_table_size(int value);
        s_valid = 1'b0;
        wait (pending_desc.size() == 0);
        repeat (100) @(negedge aclk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = 3'(4 * ndat_pkg::REG_TABLE_SIZE); pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        sh_table_size = value;
    endtask

    function automatic req_t random_req();
        req_t r;
        int pick, lim;
        r = '0;
        r.byte_offset = {$urandom(), $urandom()};
        r.block_index = $urandom();
        r.phys_block = $urandom();
        r.block_mapped = $urandom();
        r.patch_page = $urandom();
        r.patch_confidence = $urandom();
        r.patch_source = $urandom();
        pick = $urandom_range(0, 99);
        lim = (sh_table_size == 0) ? 1 : sh_table_size;
        if (pick < 25) begin
            r.req_type = ndat_pkg::REQ_WRITE;
            if ($urandom_range(0, 3) != 0) r.block_index = $urandom_range(0, 3);
        end else if (pick < 50) begin
            r.req_type = ndat_pkg::REQ_INSTALL;
            case ($urandom_range(0, 9))
                0: r.patch_sector = $urandom();
                1: r.patch_sector = 0;
                default: r.patch_sector = $urandom_range(0, 8191);
            endcase
        end else if (pick < 95) begin
            r.req_type = ndat_pkg::REQ_TRANSLATE;
            case ($urandom_range(0, 9))
                0: r.request_length = $urandom();
                1: r.request_length = 0;
                default: r.request_length = $urandom_range(1, 3000);
            endcase
            case ($urandom_range(0, 9))
                0, 1: ;  // full-range offset
                2: r.byte_offset = longint'(lim) * BLOCK_SPAN - $urandom_range(1, 2000);
                default: r.byte_offset = $urandom_range(0, 8 * 1024 * 1024 - 1);
            endcase
        end else begin
            r.req_type = 2'd3;
        end
        return r;
    endfunction

    function automatic row_t trow(logic [1:0] t, longint ofs, int len, int idx, int pb, bit mp,
                                  longint psec, int ppg, int conf, int src,
                                  bit typed, logic [2:0] kind, logic [1:0] st);
        row_t w;
        w.cfg = 0; w.cfg_value = 0; w.typed = typed;
        w.req.req_type = t; w.req.byte_offset = ofs; w.req.request_length = len;
        w.req.block_index = idx; w.req.phys_block = pb; w.req.block_mapped = mp;
        w.req.patch_sector = psec; w.req.patch_page = ppg;
        w.req.patch_confidence = conf; w.req.patch_source = src;
        w.answer = make_desc(kind, st, 0, 0, 0, 0);
        return w;
    endfunction

    function automatic row_t crow(int value);
        row_t w;
        w = '{cfg: 1, cfg_value: value, req: '0, typed: 0, answer: '0};
        return w;
    endfunction

    // stimulus
    initial begin
        row_t rows[$];
        req_t r;
        desc_t none;
        none = '0;
        fail_count = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        s_valid = 0; s_req = '0;
        foreach (blk_written[b]) begin
            blk_written[b] = 0;
            blk_map[b] = '0;
        end
        foreach (sh_sector[i]) begin
            sh_sector[i] = 0; sh_page[i] = 0; sh_conf[i] = 0; sh_src[i] = 0;
        end
        sh_table_size = 0;
        aresetn = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty table, then table extremes, patches, chunk splits
        rows.push_back(trow(ndat_pkg::REQ_TRANSLATE, 0, 100, 0, 0, 0, 0, 0, 0, 0,
                            1, ndat_pkg::KIND_END, 0));
        rows.push_back(trow(ndat_pkg::REQ_TRANSLATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(trow(ndat_pkg::REQ_INSTALL, 0, 0, 0, 0, 0, 0, 5, 9, 1,
                            1, ndat_pkg::KIND_ACK, ndat_pkg::ACK_IGNORED));
        rows.push_back(trow(2'd3, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                            1, ndat_pkg::KIND_ACK, ndat_pkg::ACK_IGNORED));
        rows.push_back(trow(ndat_pkg::REQ_WRITE, 0, 0, 0, 'hFFFF, 1, 0, 0, 0, 0,
                            1, ndat_pkg::KIND_ACK, ndat_pkg::ACK_WRITTEN));
        rows.push_back(trow(ndat_pkg::REQ_WRITE, 0, 0, 4095, 0, 1, 0, 0, 0, 0,
                            1, ndat_pkg::KIND_ACK, ndat_pkg::ACK_WRITTEN));
        rows.push_back(trow(ndat_pkg::REQ_WRITE, 0, 0, 1, 'h1234, 0, 0, 0, 0, 0,
                            1, ndat_pkg::KIND_ACK, ndat_pkg::ACK_WRITTEN));
        rows.push_back(crow(4096));
        rows.push_back(trow(ndat_pkg::REQ_TRANSLATE, 0, 3000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(trow(ndat_pkg::REQ_TRANSLATE, 'h3_FFFF_FFFF, 'h7FFF, 0, 0, 0, 0, 0, 0, 0,
                            0, 0, 0));
        rows.push_back(trow(ndat_pkg::REQ_TRANSLATE, BLOCK_SPAN - 100, 2000, 0, 0, 0, 0, 0, 0,
                            0, 0, 0, 0));
        rows.push_back(trow(ndat_pkg::REQ_INSTALL, 0, 0, 0, 0, 0, 17, 0, -32768, 2,
                            1, ndat_pkg::KIND_ACK, ndat_pkg::ACK_KEPT));
        rows.push_back(trow(ndat_pkg::REQ_INSTALL, 0, 0, 0, 0, 0, 16, 3, 5, 7,
                            1, ndat_pkg::KIND_ACK, ndat_pkg::ACK_WRITTEN));
        rows.push_back(trow(ndat_pkg::REQ_INSTALL, 0, 0, 0, 0, 0, 16, 4, 5, 8,
                            1, ndat_pkg::KIND_ACK, ndat_pkg::ACK_KEPT));
        rows.push_back(trow(ndat_pkg::REQ_INSTALL, 0, 0, 0, 0, 0, 16, 'hFFFF, 6, 15,
                            1, ndat_pkg::KIND_ACK, ndat_pkg::ACK_WRITTEN));
        rows.push_back(trow(ndat_pkg::REQ_INSTALL, 0, 0, 0, 0, 0, 'hFFFF_FFFF, 1, 32767, 0,
                            1, ndat_pkg::KIND_ACK, ndat_pkg::ACK_WRITTEN));
        rows.push_back(trow(ndat_pkg::REQ_TRANSLATE, 8192 - 10, 9000, 0, 0, 0, 0, 0, 0, 0,
                            0, 0, 0));
        rows.push_back(trow(ndat_pkg::REQ_TRANSLATE, BLOCK_SPAN + 500, 1024, 0, 0, 0, 0, 0, 0,
                            0, 0, 0, 0));
        rows.push_back(crow(1));
        rows.push_back(trow(ndat_pkg::REQ_TRANSLATE, BLOCK_SPAN - 512, 1024, 0, 0, 0, 0, 0, 0,
                            0, 0, 0, 0));
        rows.push_back(trow(ndat_pkg::REQ_TRANSLATE, BLOCK_SPAN, 16, 0, 0, 0, 0, 0, 0, 0,
                            1, ndat_pkg::KIND_END, 0));
        foreach (rows[i]) begin
            if (rows[i].cfg) set_table_size(rows[i].cfg_value);
            else send_req(rows[i].req, rows[i].typed, rows[i].answer);
        end

        // random phases over several table sizes
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: set_table_size(4096);
                1: set_table_size($urandom_range(2, 4095));
                2: set_table_size(1);
                default: set_table_size(4096);
            endcase
            repeat (62) begin
                r = random_req();
                if (r.req_type == ndat_pkg::REQ_TRANSLATE) cover_blocks(r);
                send_req(r, 1'b0, none);
            end
        end
        s_valid = 1'b0;
        wait (pending_desc.size() == 0);
        repeat (100) @(negedge aclk);
        if (fail_count == 0) $display("** nand_dump_address_translator_top: PASSED **");
        else $display("** nand_dump_address_translator_top: FAILED **");
        $finish;
    end

    // result side: random stalls, short mostly, sometimes long, sometimes none
    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 2) == 0) begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge aclk);
        end
    end

    // check each accepted descriptor against the oldest expectation
    always @(posedge aclk) begin
        desc_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_desc.size() == 0) begin
                $display("%0t: unexpected result kind=%0d status=%0d cs=%0d src=%0d addr=%0h len=%0d last=%0d",
                         $time, m_desc.kind, m_desc.status, m_desc.chip_select,
                         m_desc.source_id, m_desc.phys_address, m_desc.chunk_length,
                         m_desc.last);
                fail_count++;
            end else begin
                want = pending_desc.pop_front();
                if (want !== m_desc) begin
                    $display("%0t: mismatch expected kind=%0d status=%0d cs=%0d src=%0d addr=%0h len=%0d last=%0d",
                             $time, want.kind, want.status, want.chip_select, want.source_id,
                             want.phys_address, want.chunk_length, want.last);
                    $display("%0t:          actual   kind=%0d status=%0d cs=%0d src=%0d addr=%0h len=%0d last=%0d",
                             $time, m_desc.kind, m_desc.status, m_desc.chip_select,
                             m_desc.source_id, m_desc.phys_address, m_desc.chunk_length,
                             m_desc.last);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("%0t: timeout, %0d results outstanding", $time, pending_desc.size());
                $display("** nand_dump_address_translator_top: FAILED **");
                $finish;
            end
        end
    end

endmodule

// ===== sim.f =====
hdl/ndat_pkg.sv
hdl/ndat_ctrl.sv
hdl/ndat_datapath.sv
hdl/nand_dump_address_translator_top.sv
tb/nand_dump_address_translator_top_tb.sv
